@@ sv/rida_pkg.sv @@
// Shared types and codes for the request ID allocator.
// No dependencies; imported by rida_scan and request_id_allocator.
`default_nettype none

package rida_pkg;

  // Operation codes carried on in_tuser
  localparam logic [1:0] FN_ALLOC   = 2'd0;
  localparam logic [1:0] FN_FREE    = 2'd1;
  localparam logic [1:0] FN_REALLOC = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Busy marks examined by the search unit per step
  localparam int SCAN_LANES = 8;

  // Status of one search step
  typedef struct packed {
    logic hit;   // a free ID was found in this window
    logic last;  // this window reaches the end of the table
  } scan_res_t;

endpackage

`default_nettype wire

@@ sv/rida_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rida_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/rida_scan.sv @@
// Search step unit: examines a window of busy marks from a rotating start.
// Depends on rida_pkg for the lane count and the step status struct.
`default_nettype none

module rida_scan
  import rida_pkg::*;
#(
  parameter int ID_COUNT = 256
) (
  input  wire logic [ID_COUNT-1:0]                           busy,
  input  wire logic [(ID_COUNT > 1 ? $clog2(ID_COUNT) : 1)-1:0] pos,
  input  wire logic [$clog2(ID_COUNT + SCAN_LANES):0]        scanned,
  output logic      [(ID_COUNT > 1 ? $clog2(ID_COUNT) : 1)-1:0] slot,
  output logic      [(ID_COUNT > 1 ? $clog2(ID_COUNT) : 1)-1:0] next_pos,
  output scan_res_t                                          res
);

  localparam int IDX_W = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int LANES = (ID_COUNT < SCAN_LANES) ? ID_COUNT : SCAN_LANES;
  localparam int SCN_W = $clog2(ID_COUNT + SCAN_LANES) + 1;

  // Walk lanes from high to low so the lowest free lane wins
  always_comb begin
    logic [IDX_W:0] sum;
    res.hit = 1'b0;
    slot    = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      sum = {1'b0, pos} + (IDX_W + 1)'(i);
      if (sum >= (IDX_W + 1)'(ID_COUNT)) begin
        sum = sum - (IDX_W + 1)'(ID_COUNT);
      end
      if (((scanned + SCN_W'(i)) < SCN_W'(ID_COUNT)) && !busy[sum[IDX_W-1:0]]) begin
        res.hit = 1'b1;
        slot    = sum[IDX_W-1:0];
      end
    end
  end

  always_comb begin
    logic [IDX_W:0] nsum;
    nsum = {1'b0, pos} + (IDX_W + 1)'(LANES);
    if (nsum >= (IDX_W + 1)'(ID_COUNT)) begin
      nsum = nsum - (IDX_W + 1)'(ID_COUNT);
    end
    next_pos = nsum[IDX_W-1:0];
    res.last = (scanned + SCN_W'(LANES)) >= SCN_W'(ID_COUNT);
  end

endmodule

`default_nettype wire

@@ sv/request_id_allocator.sv @@
// Request ID allocator top level: sequencer, busy marks, busy count, output register.
// Depends on rida_pkg, rida_ram (owner tags) and rida_scan (free ID search).
`default_nettype none

// The allocator hands out request IDs 0..ID_COUNT-1. Each request on the
// input stream carries its operation in in_tuser (allocate, free, reallocate)
// and the owner tag, held ID and random search start in in_tdata; one result
// per request comes back on the output stream with a status, the granted ID
// and the busy count after the request. Busy marks live in flip-flops and are
// all cleared by reset, so the block is ready right after reset; owner tags
// live in a RAM that is never cleared, since a tag is only used for a busy
// ID. A request is taken only while the sequencer is idle. A free, an error
// or an unknown operation passes through accept with the owner RAM read,
// check and result. An allocate or reallocate adds a start reduction state,
// which subtracts ID_COUNT from the start until it is in range (no
// subtraction when ID_COUNT is 256), and the search, which examines 8 busy
// marks per cycle from the rotating start until it finds a free ID or has
// covered the table. The result enters the output register at the end of
// the result state and waits there while the next request is accepted; the
// result state stalls while the output register still holds a result that
// has not been taken.
module request_id_allocator
  import rida_pkg::*;
#(
  parameter int ID_COUNT   = 256,
  parameter int OWNER_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // owner_tag[15:0], held_id[23:16], random_start[31:24]
  input  wire logic [1:0]  in_tuser,   // func[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata   // status[1:0], granted_id[9:2], busy_count[18:10], zero pad
);

  localparam int IDX_W = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int CNT_W = $clog2(ID_COUNT + 1);
  localparam int SCN_W = $clog2(ID_COUNT + SCAN_LANES) + 1;
  localparam int LANES = (ID_COUNT < SCAN_LANES) ? ID_COUNT : SCAN_LANES;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_REDUCE = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0]            st_r;
  logic [ID_COUNT-1:0]   busy_r;
  logic [CNT_W-1:0]      count_r;
  logic                  out_valid_r;

  // Request payload and working registers
  logic [1:0]            func_r;
  logic [OWNER_BITS-1:0] tag_r;
  logic [7:0]            held_r;
  logic [7:0]            pos_r;
  logic [SCN_W-1:0]      scanned_r;
  logic [1:0]            status_r;
  logic [7:0]            granted_r;

  // Output register
  logic [1:0]            out_status_r;
  logic [7:0]            out_granted_r;
  logic [8:0]            out_count_r;

  logic                  in_acc;
  logic                  out_load;
  logic [IDX_W-1:0]      held_idx;
  logic                  held_in_range;
  logic                  held_busy;
  logic [OWNER_BITS-1:0] owner_rd;
  logic [IDX_W-1:0]      scan_slot;
  logic [IDX_W-1:0]      scan_next;
  scan_res_t             scan_res;
  logic                  tbl_we;

  assign in_tready     = (st_r == S_IDLE);
  assign in_acc        = in_tvalid && in_tready;
  assign out_load      = (st_r == S_RESP) && (!out_valid_r || out_tready);
  assign held_idx      = held_r[IDX_W-1:0];
  assign held_in_range = {1'b0, held_r} < 9'(ID_COUNT);
  assign held_busy     = held_in_range && busy_r[held_idx];
  assign tbl_we        = (st_r == S_SEARCH) && scan_res.hit;

  // Owner tags: read at the held ID on acceptance, written at the granted ID
  rida_ram #(
    .WIDTH (OWNER_BITS),
    .DEPTH (ID_COUNT)
  ) u_owner (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (scan_slot),
    .wdata (tag_r),
    .re    (in_acc),
    .raddr (in_tdata[16 +: IDX_W]),
    .rdata (owner_rd)
  );

  rida_scan #(
    .ID_COUNT (ID_COUNT)
  ) u_scan (
    .busy     (busy_r),
    .pos      (pos_r[IDX_W-1:0]),
    .scanned  (scanned_r),
    .slot     (scan_slot),
    .next_pos (scan_next),
    .res      (scan_res)
  );

  // Control state: sequencer, busy marks, busy count, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      busy_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            st_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          case (func_r)
            FN_ALLOC: st_r <= S_REDUCE;
            FN_FREE: begin
              // Release an owned ID on the spot
              if (held_busy && owner_rd == tag_r) begin
                busy_r[held_idx] <= 1'b0;
                count_r          <= count_r - CNT_W'(1);
              end
              st_r <= S_RESP;
            end
            FN_REALLOC: begin
              st_r <= (held_busy && owner_rd == tag_r) ? S_REDUCE : S_RESP;
            end
            default: st_r <= S_RESP;
          endcase
        end
        S_REDUCE: begin
          if ({1'b0, pos_r} < 9'(ID_COUNT)) begin
            st_r <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (scan_res.hit) begin
            // Mark the new ID busy; a reallocate drops the old one as well
            if (func_r == FN_ALLOC) begin
              busy_r  <= busy_r | (ID_COUNT'(1) << scan_slot);
              count_r <= count_r + CNT_W'(1);
            end else begin
              busy_r <= (busy_r | (ID_COUNT'(1) << scan_slot)) &
                        ~(ID_COUNT'(1) << held_idx);
            end
            st_r <= S_RESP;
          end else if (scan_res.last) begin
            st_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_load) begin
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          func_r    <= in_tuser;
          tag_r     <= OWNER_BITS'(in_tdata[15:0]);
          held_r    <= in_tdata[23:16];
          pos_r     <= in_tdata[31:24];
          status_r  <= ST_INVALID;
          granted_r <= '0;
        end
      end
      S_CHECK: begin
        if (func_r == FN_FREE || func_r == FN_REALLOC) begin
          if (!held_busy) begin
            status_r <= ST_INVALID;
          end else if (owner_rd != tag_r) begin
            status_r <= ST_MISMATCH;
          end else begin
            status_r <= ST_OK;
          end
        end
      end
      S_REDUCE: begin
        // Bring the start offset into range, one subtraction per cycle
        if ({1'b0, pos_r} >= 9'(ID_COUNT)) begin
          pos_r <= pos_r - 8'(ID_COUNT);
        end
        scanned_r <= '0;
      end
      S_SEARCH: begin
        if (scan_res.hit) begin
          status_r  <= ST_OK;
          granted_r <= 8'(scan_slot);
        end else if (scan_res.last) begin
          status_r <= ST_FULL;
        end else begin
          scanned_r <= scanned_r + SCN_W'(LANES);
          pos_r     <= 8'(scan_next);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_status_r  <= status_r;
      out_granted_r <= granted_r;
      out_count_r   <= 9'(count_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_count_r, out_granted_r, out_status_r};

  // The busy count always tracks the number of busy marks
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(busy_r) == int'(count_r))
    else $error("busy count differs from busy marks");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= ID_COUNT)
    else $error("busy count above table size");

  // A granted ID is marked busy right after the search hit
  a_grant_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SEARCH && scan_res.hit) |=> busy_r[granted_r[IDX_W-1:0]])
    else $error("granted ID not marked busy");

  // Every failing request reports ID zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_granted_r == 8'd0))
    else $error("error result carries a nonzero ID");

endmodule

`default_nettype wire
